// ===== rtl/core/jets_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_pkg
// Shared widths, constants, controller codes and the command and status
// types of the Julia escape-time point evaluator.
// ----------------------------------------------------------------------------
package jets_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 10;
  localparam int THR_BITS  = 28;
  localparam int CNT_BITS  = 11;
  localparam int IDX_BITS  = 2;

  // Squares carry 2*WORD_BITS-FRAC_BITS bits, the doubled cross product one more
  localparam int SQ_BITS   = 2 * WORD_BITS - FRAC_BITS;
  localparam int XP_BITS   = SQ_BITS + 1;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int MAG_BITS  = SQ_BITS;

  localparam logic [MAG_BITS-1:0] MAG_FOUR = MAG_BITS'(4) << FRAC_BITS;

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_C_REAL   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_C_IMAG   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MAX_ITER = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_CONV_THR = 2'd3;

  // Configuration reset values
  localparam logic [WORD_BITS-1:0] C_REAL_RST   = 32'sd26854283;
  localparam logic [WORD_BITS-1:0] C_IMAG_RST   = -32'sd307479393;
  localparam logic [ITER_BITS-1:0] MAX_ITER_RST = 10'd101;
  localparam logic [THR_BITS-1:0]  CONV_THR_RST = 28'd268;

  // Controller state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
  } jets_cmd_t;

  typedef struct packed {
    logic stop;
  } jets_status_t;

  // Saturate a wide signed sum to the signed word range
  function automatic logic signed [WORD_BITS-1:0] clamp_word(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v[SUM_BITS-1:WORD_BITS-1] == {(SUM_BITS-WORD_BITS+1){1'b0}} ||
        v[SUM_BITS-1:WORD_BITS-1] == {(SUM_BITS-WORD_BITS+1){1'b1}}) begin
      r = v[WORD_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/jets_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_ctrl
// Sequencer: loads a request, then alternates multiply and update phases
// until the datapath reports a stop, and strobes done once.
// ----------------------------------------------------------------------------
module jets_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  jets_pkg::jets_status_t status,
  output jets_pkg::jets_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import jets_pkg::*;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (status.stop) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/core/jets_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_datapath
// Configuration registers, z state, squaring multipliers and the update
// step with saturation, stop tests and result capture.
// ----------------------------------------------------------------------------
module jets_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [jets_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [jets_pkg::WORD_BITS-1:0]         cfg_data,
  input  logic signed [jets_pkg::WORD_BITS-1:0]  point_real,
  input  logic signed [jets_pkg::WORD_BITS-1:0]  point_imag,
  input  jets_pkg::jets_cmd_t                    cmd,
  output jets_pkg::jets_status_t                 status,
  output logic                                   escaped,
  output logic                                   plot_point,
  output logic [jets_pkg::CNT_BITS-1:0]          iter_count
);
  import jets_pkg::*;

  logic signed [WORD_BITS-1:0]   c_real;
  logic signed [WORD_BITS-1:0]   c_imag;
  logic [ITER_BITS-1:0]          max_iter;
  logic [THR_BITS-1:0]           conv_threshold;

  logic signed [WORD_BITS-1:0]   z_re;
  logic signed [WORD_BITS-1:0]   z_im;
  logic [MAG_BITS-1:0]           prev_mag_sq;
  logic [CNT_BITS-1:0]           counter;
  logic                          first;

  logic signed [SQ_BITS-1:0]     sq_re;
  logic signed [SQ_BITS-1:0]     sq_im;
  logic signed [XP_BITS-1:0]     cross2;

  logic signed [2*WORD_BITS-1:0] prod_rr;
  logic signed [2*WORD_BITS-1:0] prod_ii;
  logic signed [2*WORD_BITS-1:0] prod_ri;

  logic [MAG_BITS-1:0]           mag_sq;
  logic [MAG_BITS-1:0]           mag_diff;
  logic signed [SUM_BITS-1:0]    re_sum;
  logic signed [SUM_BITS-1:0]    im_sum;
  logic signed [WORD_BITS-1:0]   z_re_next;
  logic signed [WORD_BITS-1:0]   z_im_next;
  logic [CNT_BITS-1:0]           counter_next;
  logic                          stop_mag;
  logic                          stop_limit;
  logic                          stop_conv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real         <= C_REAL_RST;
      c_imag         <= C_IMAG_RST;
      max_iter       <= MAX_ITER_RST;
      conv_threshold <= CONV_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C_REAL:   c_real         <= cfg_data;
        REG_C_IMAG:   c_imag         <= cfg_data;
        REG_MAX_ITER: max_iter       <= cfg_data[ITER_BITS-1:0];
        REG_CONV_THR: conv_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign prod_rr = z_re * z_re;
  assign prod_ii = z_im * z_im;
  assign prod_ri = z_re * z_im;

  // Update phase works on the registered products of the current z
  assign mag_sq    = MAG_BITS'($unsigned(sq_re)) + MAG_BITS'($unsigned(sq_im));
  assign re_sum    = SUM_BITS'(sq_re) - SUM_BITS'(sq_im) + SUM_BITS'(c_real);
  assign im_sum    = SUM_BITS'(cross2) + SUM_BITS'(c_imag);
  assign z_re_next = clamp_word(re_sum);
  assign z_im_next = clamp_word(im_sum);
  assign mag_diff  = (mag_sq >= prev_mag_sq) ? (mag_sq - prev_mag_sq)
                                             : (prev_mag_sq - mag_sq);

  assign stop_mag     = (mag_sq >= MAG_FOUR);
  assign stop_limit   = (counter > {1'b0, max_iter});
  assign stop_conv    = (mag_diff <= MAG_BITS'(conv_threshold));
  // Counter advances only while the magnitude stays below four
  assign counter_next = stop_mag ? counter : counter + CNT_BITS'(1);

  // The products of the start point only seed the first pass
  assign status.stop = !first && (stop_mag || stop_limit || stop_conv);

  always_ff @(posedge clk) begin
    if (rst) begin
      first   <= 1'b1;
      counter <= '0;
    end else if (cmd.load) begin
      first   <= 1'b1;
      counter <= '0;
    end else if (cmd.add) begin
      first <= 1'b0;
      if (!first) begin
        counter <= counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_re        <= point_real;
      z_im        <= point_imag;
      prev_mag_sq <= '0;
    end else if (cmd.add) begin
      if (first) begin
        z_re <= z_re_next;
        z_im <= z_im_next;
      end else if (!status.stop) begin
        z_re        <= z_re_next;
        z_im        <= z_im_next;
        prev_mag_sq <= mag_sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_re  <= SQ_BITS'(prod_rr >>> FRAC_BITS);
      sq_im  <= SQ_BITS'(prod_ii >>> FRAC_BITS);
      cross2 <= XP_BITS'(prod_ri >>> (FRAC_BITS - 1));
    end
  end

  // Capture the result on the stopping pass
  always_ff @(posedge clk) begin
    if (cmd.add && status.stop) begin
      escaped    <= (mag_sq > MAG_FOUR);
      plot_point <= (mag_sq > MAG_FOUR) && !counter_next[0];
      iter_count <= counter_next;
    end
  end

endmodule

// ===== rtl/core/julia_escape_time_point_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_point_top
// Julia-set escape-time evaluation of one Q4.28 complex point.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge where start is high and busy is low;
//   point_real and point_imag must be valid at that edge. The block iterates
//   z = z*z + c with c from the c_real and c_imag registers until the squared
//   magnitude reaches 4, the counter passes max_iter, or the magnitude change
//   falls to conv_threshold or below.
//   Each pass has a multiply phase for the three squaring multipliers and
//   an update phase for the sums, saturation and stop tests. A request
//   runs N passes after acceptance, N being 2 to max_iter+3; done then
//   pulses for one cycle with escaped, plot_point and iter_count, and busy
//   drops in that same cycle, so the next request may be taken there.
//   Results stay in their registers until the next request stops, and
//   the receiver cannot stall them.
//   Registers are written through cfg_we, cfg_index and cfg_data; the
//   user must write them only while idle, which the block does not enforce.
//   Synchronous reset idles the sequencer and restores register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_point_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [jets_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [jets_pkg::WORD_BITS-1:0]         cfg_data,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [jets_pkg::WORD_BITS-1:0]  point_real,
  input  logic signed [jets_pkg::WORD_BITS-1:0]  point_imag,
  output logic                                   done,
  output logic                                   escaped,
  output logic                                   plot_point,
  output logic [jets_pkg::CNT_BITS-1:0]          iter_count
);
  import jets_pkg::*;

  jets_cmd_t    cmd;
  jets_status_t status;

  jets_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  jets_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_real (point_real),
    .point_imag (point_imag),
    .cmd        (cmd),
    .status     (status),
    .escaped    (escaped),
    .plot_point (plot_point),
    .iter_count (iter_count)
  );

endmodule
